FILE: rtl/tccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared widths, codes and types of the text console cursor and scroll unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    // reciprocal scaling for the cell number to row/column split
    localparam int DIV_SHIFT = 16;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // configuration register index (byte address 4*index)
    localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT = 2'd0,
        CMD_BACK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_BACK,
        OP_CLEAR,
        OP_READ,
        OP_READ_OOR
    } op_kind_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_SCROLL,
        BK_CLEAR,
        BK_READ
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/tccs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_front
// Takes input words, decodes the command and splits a read cell number into
// row and column, then pushes one operation into the queue.
// ----------------------------------------------------------------------------
module tccs_front
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         hold,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [CMD_W-1:0]             s_cmd,
    input  wire logic [CHAR_W-1:0]            s_char_code,
    input  wire logic [IDX_W-1:0]             s_cell_index,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output op_kind_t                          push_kind,
    output logic [CHAR_W-1:0]                 push_char,
    output logic [$clog2(ROWS)-1:0]           push_row,
    output logic [$clog2(COLUMNS)-1:0]        push_col
);

    localparam int RW     = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int RECIP  = (1 << DIV_SHIFT) / COLUMNS;
    localparam int PROD_W = IDX_W + DIV_SHIFT;

    front_state_t         state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic [IDX_W-1:0]     q_est, q_fix, qc, r_raw, r_fix;
    logic                 accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_cmd);
            char_reg <= s_char_code;
            idx_reg  <= s_cell_index;
        end
        if (state_reg == FR_DIV) begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(RECIP);
        end
    end

    // quotient estimate is low by at most one
    always_comb begin
        q_est = prod_reg[DIV_SHIFT +: IDX_W];
        qc    = IDX_W'(q_est * COLUMNS);
        r_raw = idx_reg - qc;
        if (r_raw >= IDX_W'(COLUMNS)) begin
            q_fix = q_est + IDX_W'(1);
            r_fix = r_raw - IDX_W'(COLUMNS);
        end else begin
            q_fix = q_est;
            r_fix = r_raw;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        push_char  = char_reg;
        push_row   = RW'(q_fix);
        push_col   = COL_W'(r_fix);
        unique case (cmd_reg)
            CMD_PRINT: push_kind = (char_reg == CHAR_LF || char_reg == CHAR_CR) ?
                                   OP_NEWLINE : OP_PRINT;
            CMD_BACK:  push_kind = OP_BACK;
            CMD_CLEAR: push_kind = OP_CLEAR;
            CMD_READ:  push_kind = (idx_reg >= IDX_W'(CELLS)) ? OP_READ_OOR : OP_READ;
            // no word taken yet
            default:   push_kind = OP_PRINT;
        endcase
        unique case (state_reg)
            FR_IDLE: begin
                s_ready = !hold;
                if (s_valid && !hold) begin
                    state_next = (cmd_t'(s_cmd) == CMD_READ) ? FR_DIV : FR_PUSH;
                end
            end
            FR_DIV: begin
                state_next = FR_PUSH;
            end
            FR_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tccs_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_fifo
// Short operation queue between the decoder and the screen sequencer.
// ----------------------------------------------------------------------------
module tccs_fifo
    import tccs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tccs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_back
// Screen sequencer: owns the cell memory, cursor and rotating row base, and
// carries out one queued operation at a time into the result register.
// ----------------------------------------------------------------------------
module tccs_back
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ATTR_W-1:0]             attr,
    input  wire logic                          op_valid,
    output logic                               op_ready,
    input  wire op_kind_t                      op_kind,
    input  wire logic [CHAR_W-1:0]             op_char,
    input  wire logic [$clog2(ROWS)-1:0]       op_row,
    input  wire logic [$clog2(COLUMNS)-1:0]    op_col,
    output logic                               init_busy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [CURSOR_W-1:0]                m_cursor_position,
    output logic [CHAR_W-1:0]                  m_cell_char,
    output logic [ATTR_W-1:0]                  m_cell_attribute,
    output logic                               m_scrolled
);

    localparam int RW             = $clog2(ROWS);
    localparam int COL_W          = $clog2(COLUMNS);
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int LIN_W          = $clog2(CELLS);
    localparam int ADDR_W         = RW + COL_W;
    localparam int DEPTH          = ROWS * (1 << COL_W);
    localparam int LAST_ROW_START = CELLS - COLUMNS;

    // cell memory, one row per 2**COL_W entries
    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LIN_W-1:0]  lin_reg, lin_next;
    logic [RW-1:0]     base_reg, base_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    logic                m_valid_reg;
    logic [CURSOR_W-1:0] m_cursor_position_reg;
    logic [CHAR_W-1:0]   m_cell_char_reg;
    logic [ATTR_W-1:0]   m_cell_attribute_reg;
    logic                m_scrolled_reg;

    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                res_load, res_scrolled, next_line, out_free;
    logic [CURSOR_W-1:0] res_cursor;
    logic [CHAR_W-1:0]   res_char;
    logic [ATTR_W-1:0]   res_attr;
    logic                col_last, row_last;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] b);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, b};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last  = (row_reg == RW'(ROWS - 1));
    assign init_busy = (state_reg == BK_INIT);

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        lin_next     = lin_reg;
        base_next    = base_reg;
        sweep_next   = sweep_reg;
        mem_we       = 1'b0;
        mem_waddr    = sweep_reg;
        mem_wdata    = {attr, BLANK_CHAR};
        mem_re       = 1'b0;
        mem_raddr    = {phys_row(op_row, base_reg), op_col};
        op_ready     = 1'b0;
        res_load     = 1'b0;
        res_char     = '0;
        res_attr     = '0;
        res_scrolled = 1'b0;
        next_line    = 1'b0;
        unique case (state_reg)
            BK_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                if (sweep_reg == ADDR_W'(DEPTH - 1)) begin
                    sweep_next = '0;
                    state_next = BK_IDLE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            BK_IDLE: begin
                if (op_valid && out_free) begin
                    op_ready = 1'b1;
                    unique case (op_kind)
                        OP_PRINT: begin
                            mem_we    = 1'b1;
                            mem_waddr = {phys_row(row_reg, base_reg), col_reg};
                            mem_wdata = {attr, op_char};
                            lin_next  = lin_reg + LIN_W'(1);
                            res_load  = 1'b1;
                            if (col_last) begin
                                next_line = 1'b1;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        OP_NEWLINE: begin
                            lin_next  = LIN_W'(int'(lin_reg) + COLUMNS - int'(col_reg));
                            res_load  = 1'b1;
                            next_line = 1'b1;
                        end
                        OP_BACK: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - COL_W'(1);
                                lin_next = lin_reg - LIN_W'(1);
                            end else if (row_reg != '0) begin
                                row_next = row_reg - RW'(1);
                                col_next = COL_W'(COLUMNS - 1);
                                lin_next = lin_reg - LIN_W'(1);
                            end
                            mem_we    = 1'b1;
                            mem_waddr = {phys_row(row_next, base_reg), col_next};
                            res_load  = 1'b1;
                        end
                        OP_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            lin_next   = '0;
                            base_next  = '0;
                            sweep_next = '0;
                            state_next = BK_CLEAR;
                        end
                        OP_READ: begin
                            mem_re     = 1'b1;
                            state_next = BK_READ;
                        end
                        OP_READ_OOR: begin
                            res_load = 1'b1;
                        end
                        default: ;
                    endcase
                    // wrap to the next row; past the bottom the base rotates and
                    // the old top row is blanked as the new bottom row
                    if (next_line) begin
                        col_next = '0;
                        if (row_last) begin
                            lin_next   = LIN_W'(LAST_ROW_START);
                            base_next  = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + RW'(1);
                            sweep_next = {base_reg, {COL_W{1'b0}}};
                            state_next = BK_SCROLL;
                            res_load   = 1'b0;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                end
            end
            BK_SCROLL: begin
                mem_we = 1'b1;
                if (sweep_reg[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
                    res_load     = 1'b1;
                    res_scrolled = 1'b1;
                    state_next   = BK_IDLE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            BK_CLEAR: begin
                mem_we = 1'b1;
                if (sweep_reg == ADDR_W'(DEPTH - 1)) begin
                    sweep_next = '0;
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            BK_READ: begin
                res_load   = 1'b1;
                res_char   = rd_data_reg[CHAR_W-1:0];
                res_attr   = rd_data_reg[CELL_W-1:CHAR_W];
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
        res_cursor = CURSOR_W'(lin_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_INIT;
            row_reg     <= '0;
            col_reg     <= '0;
            lin_reg     <= '0;
            base_reg    <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            lin_reg   <= lin_next;
            base_reg  <= base_next;
            sweep_reg <= sweep_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_cursor_position_reg <= res_cursor;
            m_cell_char_reg       <= res_char;
            m_cell_attribute_reg  <= res_attr;
            m_scrolled_reg        <= res_scrolled;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = m_cursor_position_reg;
    assign m_cell_char       = m_cell_char_reg;
    assign m_cell_attribute  = m_cell_attribute_reg;
    assign m_scrolled        = m_scrolled_reg;

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg < RW'(ROWS - 1) || row_reg == RW'(ROWS - 1)) &&
        (int'(col_reg) < COLUMNS))
        else $error("cursor row or column out of range");

    a_cursor_linear: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(lin_reg) == int'(row_reg) * COLUMNS + int'(col_reg))
        else $error("linear cursor disagrees with row and column");

    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_valid && op_ready) |-> out_free)
        else $error("operation taken while result register is occupied");

    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_scrolled_reg) |->
        m_cursor_position_reg == CURSOR_W'(LAST_ROW_START))
        else $error("scrolled result without cursor on bottom row");

    a_no_op_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !op_ready && !res_load)
        else $error("operation handled during clearing pass");

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_scroll_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// COLUMNS by ROWS character console with cursor, scroll, backspace and clear.
// Input words (s_cmd, s_char_code, s_cell_index) enter on a valid/ready
// channel; each gives one result word on the m_ channel with the cursor cell
// number, the read cell (zero unless a read) and a scroll flag. The APB port
// holds text_attribute at byte address 0.
// Ordinary words pass the decoder's idle and push states (a read also passes
// a divide state, which splits the cell number by a reciprocal multiply) and
// are carried out in the sequencer's idle state (a read also passes a read
// state, after the registered memory read). A scroll blanks the new bottom row;
// the row base rotates so no row is copied. Clear sweeps the whole cell
// memory, ROWS*2**clog2(COLUMNS) entries (3200 by default).
// After reset the same sweep writes blanks with attribute 7; s_ready stays
// low until it ends. A stalled result waits in the output register while up
// to two more operations queue and the decoder holds one more word.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CMD_W-1:0]     s_cmd,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    input  wire logic [IDX_W-1:0]     s_cell_index,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CURSOR_W-1:0]       m_cursor_position,
    output logic [CHAR_W-1:0]         m_cell_char,
    output logic [ATTR_W-1:0]         m_cell_attribute,
    output logic                      m_scrolled
);

    localparam int RW    = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int KIND_W = $bits(op_kind_t);
    localparam int Q_W   = KIND_W + CHAR_W + RW + COL_W;

    logic [ATTR_W-1:0] text_attribute_reg, text_attribute_next;
    logic              cfg_write;

    logic              hold;
    logic              push_valid, push_ready, op_valid, op_ready;
    op_kind_t          push_kind;
    logic [CHAR_W-1:0] push_char;
    logic [RW-1:0]     push_row;
    logic [COL_W-1:0]  push_col;
    logic [Q_W-1:0]    q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTRIBUTE);

    always_comb begin
        text_attribute_next = text_attribute_reg;
        if (cfg_write) begin
            text_attribute_next = pwdata[ATTR_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == REG_TEXT_ATTRIBUTE) begin
            prdata = {{(32 - ATTR_W){1'b0}}, text_attribute_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attribute_reg <= RESET_ATTR;
        end else begin
            text_attribute_reg <= text_attribute_next;
        end
    end

    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .hold         (hold),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_kind    (push_kind),
        .push_char    (push_char),
        .push_row     (push_row),
        .push_col     (push_col)
    );

    assign q_in = {push_kind, push_char, push_row, push_col};

    tccs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (q_in),
        .out_valid (op_valid),
        .out_ready (op_ready),
        .out_data  (q_out)
    );

    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .attr              (text_attribute_reg),
        .op_valid          (op_valid),
        .op_ready          (op_ready),
        .op_kind           (op_kind_t'(q_out[Q_W-1 -: KIND_W])),
        .op_char           (q_out[RW+COL_W +: CHAR_W]),
        .op_row            (q_out[COL_W +: RW]),
        .op_col            (q_out[0 +: COL_W]),
        .init_busy         (hold),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_char       (m_cell_char),
        .m_cell_attribute  (m_cell_attribute),
        .m_scrolled        (m_scrolled)
    );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_cursor_scroll_unit. Command words go in
// on the s_ channel. A shadow copy of the screen, the cursor and the text
// attribute predicts each result word on the m_ channel, which is then
// checked field by field. A directed pass covers the edge cases. Random
// phases under several attribute settings follow, most of them with bursts
// of idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import tccs_pkg::*;

    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int CELLS         = COLUMNS * ROWS;
    // a clear sweeps ROWS*128 cells; allow that before retuning the attribute
    localparam int SETTLE_CYCLES = ROWS * 128 + 100;
    localparam int TAIL_CYCLES   = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_WORDS   = 460;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_position;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attribute;
        logic                scrolled;
    } cursor_report_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd;
    logic [CHAR_W-1:0]   s_char_code;
    logic [IDX_W-1:0]    s_cell_index;
    logic                m_valid;
    logic                m_ready;
    logic [CURSOR_W-1:0] m_cursor_position;
    logic [CHAR_W-1:0]   m_cell_char;
    logic [ATTR_W-1:0]   m_cell_attribute;
    logic                m_scrolled;

    // shadow of the console state
    logic [CELL_W-1:0]   screen_shadow [CELLS];
    int                  cursor_shadow;
    logic [ATTR_W-1:0]   attr_shadow;

    cursor_report_t      pending_reports [$];
    cursor_report_t      oldest_report;

    bit                  stalls_enabled;
    int                  ready_stall_left;
    int                  fail_count;
    int                  cycle_count;
    int                  char_count;
    int                  newline_count;
    int                  back_count;
    int                  clear_count;
    int                  read_count;
    int                  scroll_count;

    text_console_cursor_scroll_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_char_code       (s_char_code),
        .s_cell_index      (s_cell_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_char       (m_cell_char),
        .m_cell_attribute  (m_cell_attribute),
        .m_scrolled        (m_scrolled)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_cursor_scroll_unit: mismatch");
            $finish;
        end
    end

    // Works out the result word of one accepted command and updates the shadow.
    task automatic apply_console_word(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                                      input logic [IDX_W-1:0] idx);
        cursor_report_t rep;
        int i;
        rep = '0;
        if (cursor_shadow >= CELLS) cursor_shadow = 0;
        case (cmd)
            CMD_PRINT: begin
                if (ch == CHAR_LF || ch == CHAR_CR) begin
                    cursor_shadow = (cursor_shadow / COLUMNS + 1) * COLUMNS;
                    newline_count++;
                end else begin
                    screen_shadow[cursor_shadow] = {attr_shadow, ch};
                    cursor_shadow++;
                    char_count++;
                end
                if (cursor_shadow >= CELLS) begin
                    cursor_shadow -= COLUMNS;
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        screen_shadow[i] = screen_shadow[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_shadow[i] = {attr_shadow, BLANK_CHAR};
                    rep.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            CMD_BACK: begin
                if (cursor_shadow > 0) cursor_shadow--;
                screen_shadow[cursor_shadow] = {attr_shadow, BLANK_CHAR};
                back_count++;
            end
            CMD_CLEAR: begin
                cursor_shadow = 0;
                for (i = 0; i < CELLS; i++)
                    screen_shadow[i] = {attr_shadow, BLANK_CHAR};
                clear_count++;
            end
            CMD_READ: begin
                if (idx < CELLS) begin
                    rep.cell_char      = screen_shadow[idx][CHAR_W-1:0];
                    rep.cell_attribute = screen_shadow[idx][CELL_W-1:CHAR_W];
                end
                read_count++;
            end
            default: ;
        endcase
        rep.cursor_position = CURSOR_W'(cursor_shadow);
        pending_reports.push_back(rep);
    endtask

    task automatic send_word(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        if (stalls_enabled && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_char_code  <= ch;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
        apply_console_word(cmd, ch, idx);
    endtask

    task automatic wait_for_reports();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // Drains the block, lets any sweep finish, then writes the attribute.
    task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TEXT_ATTRIBUTE, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_shadow = value;
    endtask

    task automatic test_directed_basics();
        send_word(CMD_READ, 8'h00, 11'd0);
        send_word(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
        send_word(CMD_READ, 8'hFF, IDX_W'(CELLS));      // just past the end
        send_word(CMD_READ, 8'h00, 11'h7FF);
        send_word(CMD_BACK, 8'hFF, 11'h7FF);            // at home: stays at zero
        send_word(CMD_PRINT, 8'h00, 11'h7FF);
        send_word(CMD_PRINT, 8'hFF, 11'd0);
        send_word(CMD_PRINT, 8'h0E, 11'd0);
        send_word(CMD_PRINT, 8'h0F, 11'd0);
        send_word(CMD_PRINT, CHAR_CR, 11'd0);
        send_word(CMD_BACK, 8'h00, 11'd0);              // back across the row edge
        send_word(CMD_PRINT, CHAR_LF, 11'd0);
        send_word(CMD_READ, 8'h00, 11'd0);
        send_word(CMD_READ, 8'h00, 11'd1);
        send_word(CMD_READ, 8'h00, IDX_W'(COLUMNS - 1));
    endtask

    task automatic test_newline_scroll();
        while (cursor_shadow < CELLS - COLUMNS)
            send_word(CMD_PRINT, CHAR_LF, 11'd0);
        // newline on the bottom row scrolls and lands on the bottom row again
        send_word(CMD_PRINT, CHAR_LF, 11'd0);
        send_word(CMD_PRINT, CHAR_CR, 11'd0);
        send_word(CMD_READ, 8'h00, 11'd0);
        send_word(CMD_READ, 8'h00, IDX_W'(CELLS - COLUMNS));
        send_word(CMD_CLEAR, 8'hFF, 11'h7FF);
        send_word(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
    endtask

    task automatic run_random_phase(input int word_total, input bit allow_stalls);
        int sent;
        int pick;
        cmd_t cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0] idx;
        stalls_enabled = allow_stalls;
        for (sent = 0; sent < word_total; sent++) begin
            pick = $urandom_range(0, 399);
            ch   = CHAR_W'($urandom);
            idx  = IDX_W'($urandom);
            if (pick < 200) begin
                cmd = CMD_PRINT;
            end else if (pick < 260) begin
                cmd = CMD_PRINT;
                ch  = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
            end else if (pick < 300) begin
                cmd = CMD_BACK;
            end else if (pick == 300) begin
                cmd = CMD_CLEAR;
            end else if (pick < 345) begin
                cmd = CMD_READ;
                idx = IDX_W'($urandom_range(0, CELLS - 1));
            end else if (pick < 390) begin
                // look back at what was just written
                cmd = CMD_READ;
                idx = IDX_W'((cursor_shadow + CELLS - $urandom_range(1, 8)) % CELLS);
            end else begin
                cmd = CMD_READ;
                idx = IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
            end
            send_word(cmd, ch, idx);
            if (allow_stalls && $urandom_range(0, 99) == 0)
                stalls_enabled = ~stalls_enabled;
            if ($urandom_range(0, 299) == 0)
                wait_for_reports();
        end
    endtask

    // result side: random back-pressure and the field checks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result word with nothing pending: cursor_position %0d",
                           m_cursor_position);
                    fail_count++;
                end else begin
                    oldest_report = pending_reports.pop_front();
                    if (m_cursor_position !== oldest_report.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               oldest_report.cursor_position, m_cursor_position);
                        fail_count++;
                    end
                    if (m_cell_char !== oldest_report.cell_char) begin
                        $error("cell_char: expected %0h, got %0h",
                               oldest_report.cell_char, m_cell_char);
                        fail_count++;
                    end
                    if (m_cell_attribute !== oldest_report.cell_attribute) begin
                        $error("cell_attribute: expected %0h, got %0h",
                               oldest_report.cell_attribute, m_cell_attribute);
                        fail_count++;
                    end
                    if (m_scrolled !== oldest_report.scrolled) begin
                        $error("scrolled: expected %0b, got %0b",
                               oldest_report.scrolled, m_scrolled);
                        fail_count++;
                    end
                end
            end
            if (ready_stall_left != 0) begin
                ready_stall_left <= ready_stall_left - 1;
                m_ready <= 1'b0;
            end else if (stalls_enabled && $urandom_range(0, 5) == 0) begin
                ready_stall_left <= $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        s_valid          <= 1'b0;
        s_cmd            <= CMD_PRINT;
        s_char_code      <= '0;
        s_cell_index     <= '0;
        m_ready          <= 1'b0;
        ready_stall_left = 0;
        stalls_enabled   = 1'b1;
        fail_count       = 0;
        cycle_count      = 0;
        cursor_shadow    = 0;
        attr_shadow      = RESET_ATTR;
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = {RESET_ATTR, BLANK_CHAR};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_basics();
        write_text_attribute(8'hFF);
        test_newline_scroll();
        write_text_attribute(8'h00);
        run_random_phase(PHASE_WORDS, 1'b1);
        write_text_attribute(ATTR_W'($urandom));
        run_random_phase(PHASE_WORDS, 1'b1);
        write_text_attribute(8'hFF);
        run_random_phase(PHASE_WORDS, 1'b1);
        write_text_attribute(ATTR_W'($urandom));
        run_random_phase(PHASE_WORDS, 1'b0);

        wait_for_reports();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d characters, %0d newlines, %0d backspaces, %0d clears,",
                 char_count, newline_count, back_count, clear_count);
        $display("%0d cell reads and %0d scrolls over five attribute settings",
                 read_count, scroll_count);
        if (fail_count == 0) begin
            $display("text_console_cursor_scroll_unit: match");
        end else begin
            $display("text_console_cursor_scroll_unit: mismatch");
        end
        $finish;
    end

endmodule
